@@ hdl/toy_cpu_execute_stage_assert.svh @@
// assertion macros used by the toy cpu execute stage back end
`ifndef TOY_CPU_EXECUTE_STAGE_ASSERT_SVH
`define TOY_CPU_EXECUTE_STAGE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tce: same-cycle check failed");
// next-cycle implication
`define TCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tce: next-cycle check failed");
`else
`define TCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/tce_pkg.sv @@
// types, constants and codes of the toy cpu execute stage
package tce_pkg;

    localparam int REG_COUNT  = 16;
    localparam int MEM_WORDS  = 65536;
    localparam int WORD_W     = 16;
    localparam int OP_W       = 5;
    localparam int RIDX_OUT_W = 4;
    localparam int FULL_W     = 2 * WORD_W;
    localparam int RIW        = $clog2(REG_COUNT);
    localparam int MAW        = $clog2(MEM_WORDS);
    localparam int IQ_DEPTH   = 2;
    localparam int IQ_PW      = $clog2(IQ_DEPTH);
    localparam int IQ_CW      = $clog2(IQ_DEPTH + 1);
    localparam int RQ_DEPTH   = 2;
    localparam int RQ_PW      = $clog2(RQ_DEPTH);
    localparam int RQ_CW      = $clog2(RQ_DEPTH + 1);

    // jump targets are stored minus this offset
    localparam logic [FULL_W-1:0] PC_OFFSET = FULL_W'(4);

    typedef enum logic [OP_W-1:0] {
        OP_NONE  = 5'd0,
        OP_MOVE  = 5'd1,
        OP_ADD   = 5'd2,
        OP_SUB   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_NOT   = 5'd6,
        OP_NAND  = 5'd7,
        OP_NOR   = 5'd8,
        OP_XOR   = 5'd9,
        OP_CMP   = 5'd10,
        OP_JMP   = 5'd11,
        OP_BEQ   = 5'd12,
        OP_BNE   = 5'd13,
        OP_BGT   = 5'd14,
        OP_BLT   = 5'd15,
        OP_LOAD  = 5'd16,
        OP_STORE = 5'd17,
        OP_HALT  = 5'd18
    } t_opcode;

    typedef enum logic [2:0] {
        CL_NONE,
        CL_ALU,
        CL_CMP,
        CL_BRANCH,
        CL_LOAD,
        CL_STORE,
        CL_HALT
    } t_iclass;

    typedef enum logic [3:0] {
        ALU_MOVE,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOT,
        ALU_NAND,
        ALU_NOR,
        ALU_XOR
    } t_alu_op;

    typedef enum logic [2:0] {
        BR_ALWAYS,
        BR_EQ,
        BR_NE,
        BR_GT,
        BR_LT
    } t_br_cond;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_EXEC,
        ST_LOAD
    } t_back_state;

    // decoded instruction as it sits in the instruction queue
    typedef struct packed {
        t_iclass             iclass;
        t_alu_op             alu_op;
        t_br_cond            br_cond;
        logic                imm_a;
        logic                imm_b;
        logic                imm_c;
        logic                reg_bad;
        logic [WORD_W-1:0]   opd_a;
        logic [WORD_W-1:0]   opd_b;
        logic [WORD_W-1:0]   opd_c;
    } t_dec_item;

    // one result transaction
    typedef struct packed {
        logic                  reg_valid;
        logic [RIDX_OUT_W-1:0] reg_index;
        logic [WORD_W-1:0]     reg_value;
        logic                  pc_valid;
        logic [FULL_W-1:0]     pc_value;
        logic                  halted;
        logic                  bad;
    } t_result;

endpackage

@@ hdl/tce_ram.sv @@
// generic single write port ram with registered read
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/tce_front.sv @@
// front end: decodes and classifies each incoming instruction
module tce_front (
    input  logic [tce_pkg::OP_W-1:0]   i_op,
    input  logic                       i_first_is_immediate,
    input  logic                       i_second_is_immediate,
    input  logic                       i_third_is_immediate,
    input  logic [tce_pkg::WORD_W-1:0] i_first_operand,
    input  logic [tce_pkg::WORD_W-1:0] i_second_operand,
    input  logic [tce_pkg::WORD_W-1:0] i_third_operand,
    output tce_pkg::t_dec_item         o_item
);

    tce_pkg::t_iclass  cls;
    tce_pkg::t_alu_op  alu;
    tce_pkg::t_br_cond brc;
    logic              need_a;
    logic              need_b;
    logic              need_c;
    logic              need_dest;
    logic              bad_a;
    logic              bad_b;
    logic              bad_c;
    logic              bad_dest;

    // opcode to class and sub-operation
    always_comb begin
        cls = tce_pkg::CL_NONE;
        alu = tce_pkg::ALU_MOVE;
        brc = tce_pkg::BR_ALWAYS;
        unique case (tce_pkg::t_opcode'(i_op))
            tce_pkg::OP_MOVE:  begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_MOVE; end
            tce_pkg::OP_ADD:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_ADD;  end
            tce_pkg::OP_SUB:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_SUB;  end
            tce_pkg::OP_AND:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_AND;  end
            tce_pkg::OP_OR:    begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_OR;   end
            tce_pkg::OP_NOT:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_NOT;  end
            tce_pkg::OP_NAND:  begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_NAND; end
            tce_pkg::OP_NOR:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_NOR;  end
            tce_pkg::OP_XOR:   begin cls = tce_pkg::CL_ALU; alu = tce_pkg::ALU_XOR;  end
            tce_pkg::OP_CMP:   begin cls = tce_pkg::CL_CMP; end
            tce_pkg::OP_JMP:   begin cls = tce_pkg::CL_BRANCH; brc = tce_pkg::BR_ALWAYS; end
            tce_pkg::OP_BEQ:   begin cls = tce_pkg::CL_BRANCH; brc = tce_pkg::BR_EQ; end
            tce_pkg::OP_BNE:   begin cls = tce_pkg::CL_BRANCH; brc = tce_pkg::BR_NE; end
            tce_pkg::OP_BGT:   begin cls = tce_pkg::CL_BRANCH; brc = tce_pkg::BR_GT; end
            tce_pkg::OP_BLT:   begin cls = tce_pkg::CL_BRANCH; brc = tce_pkg::BR_LT; end
            tce_pkg::OP_LOAD:  begin cls = tce_pkg::CL_LOAD;  end
            tce_pkg::OP_STORE: begin cls = tce_pkg::CL_STORE; end
            tce_pkg::OP_HALT:  begin cls = tce_pkg::CL_HALT;  end
            default:           begin cls = tce_pkg::CL_NONE;  end
        endcase
    end

    // which operands each class reads
    always_comb begin
        need_a    = (cls != tce_pkg::CL_NONE) && (cls != tce_pkg::CL_HALT);
        need_b    = need_a && !((cls == tce_pkg::CL_ALU)
                                && (alu == tce_pkg::ALU_MOVE || alu == tce_pkg::ALU_NOT));
        need_c    = (cls == tce_pkg::CL_STORE);
        need_dest = (cls == tce_pkg::CL_ALU) || (cls == tce_pkg::CL_LOAD);
    end

    // register index range checks
    assign bad_a    = need_a && !i_first_is_immediate
                      && (i_first_operand >= tce_pkg::WORD_W'(tce_pkg::REG_COUNT));
    assign bad_b    = need_b && !i_second_is_immediate
                      && (i_second_operand >= tce_pkg::WORD_W'(tce_pkg::REG_COUNT));
    assign bad_c    = need_c && !i_third_is_immediate
                      && (i_third_operand >= tce_pkg::WORD_W'(tce_pkg::REG_COUNT));
    assign bad_dest = need_dest
                      && (i_third_operand >= tce_pkg::WORD_W'(tce_pkg::REG_COUNT));

    always_comb begin
        o_item.iclass  = cls;
        o_item.alu_op  = alu;
        o_item.br_cond = brc;
        o_item.imm_a   = i_first_is_immediate;
        o_item.imm_b   = i_second_is_immediate;
        o_item.imm_c   = i_third_is_immediate;
        o_item.reg_bad = bad_a || bad_b || bad_c || bad_dest;
        o_item.opd_a   = i_first_operand;
        o_item.opd_b   = i_second_operand;
        o_item.opd_c   = i_third_operand;
    end

endmodule

@@ hdl/tce_iq.sv @@
// short instruction queue between the front end and the back end
module tce_iq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tce_pkg::t_dec_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output tce_pkg::t_dec_item o_item
);

    tce_pkg::t_dec_item              r_slot [tce_pkg::IQ_DEPTH];
    logic [tce_pkg::IQ_PW-1:0]       r_wr_ptr;
    logic [tce_pkg::IQ_PW-1:0]       r_rd_ptr;
    logic [tce_pkg::IQ_CW-1:0]       r_count;
    logic [tce_pkg::IQ_PW-1:0]       n_wr_ptr;
    logic [tce_pkg::IQ_PW-1:0]       n_rd_ptr;
    logic [tce_pkg::IQ_CW-1:0]       n_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == tce_pkg::IQ_CW'(tce_pkg::IQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == tce_pkg::IQ_PW'(tce_pkg::IQ_DEPTH - 1))
                       ? '0 : r_wr_ptr + tce_pkg::IQ_PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == tce_pkg::IQ_PW'(tce_pkg::IQ_DEPTH - 1))
                       ? '0 : r_rd_ptr + tce_pkg::IQ_PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + tce_pkg::IQ_CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - tce_pkg::IQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/tce_back.sv @@
// back end: operand read, execute, memory access and result queue
`include "toy_cpu_execute_stage_assert.svh"

module tce_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_iq_valid,
    input  tce_pkg::t_dec_item i_iq_item,
    output logic               o_iq_pop,
    output logic               o_clearing,
    input  logic               i_pop,
    output logic               o_empty,
    output tce_pkg::t_result   o_result
);

    tce_pkg::t_back_state          r_state;
    tce_pkg::t_back_state          n_state;
    logic [tce_pkg::MAW-1:0]       r_clr_addr;
    logic [tce_pkg::MAW-1:0]       n_clr_addr;
    logic                          r_flag_eq;
    logic                          r_flag_gt;
    logic                          r_flag_lt;
    logic                          n_flag_eq;
    logic                          n_flag_gt;
    logic                          n_flag_lt;
    tce_pkg::t_dec_item            r_cur;

    tce_pkg::t_result              r_rq [tce_pkg::RQ_DEPTH];
    logic [tce_pkg::RQ_PW-1:0]     r_rq_wr;
    logic [tce_pkg::RQ_PW-1:0]     r_rq_rd;
    logic [tce_pkg::RQ_CW-1:0]     r_rq_count;
    logic [tce_pkg::RQ_PW-1:0]     n_rq_wr;
    logic [tce_pkg::RQ_PW-1:0]     n_rq_rd;
    logic [tce_pkg::RQ_CW-1:0]     n_rq_count;

    logic                          rf_re;
    logic                          rf_we;
    logic [tce_pkg::RIW-1:0]       rf_waddr;
    logic [tce_pkg::WORD_W-1:0]    rf_wdata;
    logic [tce_pkg::WORD_W-1:0]    rf_rdata_a;
    logic [tce_pkg::WORD_W-1:0]    rf_rdata_b;
    logic [tce_pkg::WORD_W-1:0]    rf_rdata_c;

    logic                          dm_we;
    logic [tce_pkg::MAW-1:0]       dm_waddr;
    logic [tce_pkg::WORD_W-1:0]    dm_wdata;
    logic                          dm_re;
    logic [tce_pkg::WORD_W-1:0]    dm_rdata;

    logic [tce_pkg::WORD_W-1:0]    val_a;
    logic [tce_pkg::WORD_W-1:0]    val_b;
    logic [tce_pkg::WORD_W-1:0]    val_c;
    logic [tce_pkg::FULL_W-1:0]    full_addr;
    logic                          mem_bad;
    logic                          taken;
    logic                          exec_bad;
    logic [tce_pkg::WORD_W-1:0]    alu_res;
    logic                          rq_full;
    logic                          rq_push;
    logic                          rq_pop;
    logic                          iq_pop;
    tce_pkg::t_result              push_res;

    // register file copies, one per operand read port
    assign rf_re = (r_state == tce_pkg::ST_READ) && i_iq_valid;

    tce_ram #(.WIDTH(tce_pkg::WORD_W), .DEPTH(tce_pkg::REG_COUNT)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (i_iq_item.opd_a[tce_pkg::RIW-1:0]),
        .o_rdata (rf_rdata_a)
    );

    tce_ram #(.WIDTH(tce_pkg::WORD_W), .DEPTH(tce_pkg::REG_COUNT)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (i_iq_item.opd_b[tce_pkg::RIW-1:0]),
        .o_rdata (rf_rdata_b)
    );

    tce_ram #(.WIDTH(tce_pkg::WORD_W), .DEPTH(tce_pkg::REG_COUNT)) u_rf_c (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (rf_re),
        .i_raddr (i_iq_item.opd_c[tce_pkg::RIW-1:0]),
        .o_rdata (rf_rdata_c)
    );

    // data memory
    tce_ram #(.WIDTH(tce_pkg::WORD_W), .DEPTH(tce_pkg::MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (full_addr[tce_pkg::MAW-1:0]),
        .o_rdata (dm_rdata)
    );

    // operand selection and address
    assign val_a     = r_cur.imm_a ? r_cur.opd_a : rf_rdata_a;
    assign val_b     = r_cur.imm_b ? r_cur.opd_b : rf_rdata_b;
    assign val_c     = r_cur.imm_c ? r_cur.opd_c : rf_rdata_c;
    assign full_addr = {val_b, val_a};
    assign mem_bad   = (full_addr >= tce_pkg::FULL_W'(tce_pkg::MEM_WORDS));

    // branch condition from current flags
    always_comb begin
        unique case (r_cur.br_cond)
            tce_pkg::BR_ALWAYS: taken = 1'b1;
            tce_pkg::BR_EQ:     taken = r_flag_eq;
            tce_pkg::BR_NE:     taken = !r_flag_eq;
            tce_pkg::BR_GT:     taken = r_flag_gt;
            tce_pkg::BR_LT:     taken = r_flag_lt;
            default:            taken = 1'b0;
        endcase
    end

    // alu
    always_comb begin
        unique case (r_cur.alu_op)
            tce_pkg::ALU_MOVE: alu_res = val_a;
            tce_pkg::ALU_ADD:  alu_res = val_a + val_b;
            tce_pkg::ALU_SUB:  alu_res = val_a - val_b;
            tce_pkg::ALU_AND:  alu_res = val_a & val_b;
            tce_pkg::ALU_OR:   alu_res = val_a | val_b;
            tce_pkg::ALU_NOT:  alu_res = ~val_a;
            tce_pkg::ALU_NAND: alu_res = ~(val_a & val_b);
            tce_pkg::ALU_NOR:  alu_res = ~(val_a | val_b);
            tce_pkg::ALU_XOR:  alu_res = val_a ^ val_b;
            default:           alu_res = '0;
        endcase
    end

    // range fault per class; an untaken branch reads nothing
    always_comb begin
        unique case (r_cur.iclass)
            tce_pkg::CL_ALU,
            tce_pkg::CL_CMP:    exec_bad = r_cur.reg_bad;
            tce_pkg::CL_BRANCH: exec_bad = taken && r_cur.reg_bad;
            tce_pkg::CL_LOAD,
            tce_pkg::CL_STORE:  exec_bad = r_cur.reg_bad || mem_bad;
            default:            exec_bad = 1'b0;
        endcase
    end

    assign rq_full = (r_rq_count == tce_pkg::RQ_CW'(tce_pkg::RQ_DEPTH));

    // sequencer: clear pass, operand read, execute, load write-back
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_flag_eq  = r_flag_eq;
        n_flag_gt  = r_flag_gt;
        n_flag_lt  = r_flag_lt;
        rf_we      = 1'b0;
        rf_waddr   = r_cur.opd_c[tce_pkg::RIW-1:0];
        rf_wdata   = '0;
        dm_we      = 1'b0;
        dm_waddr   = full_addr[tce_pkg::MAW-1:0];
        dm_wdata   = val_c;
        dm_re      = 1'b0;
        iq_pop     = 1'b0;
        rq_push    = 1'b0;
        push_res   = '0;
        unique case (r_state)
            tce_pkg::ST_CLEAR: begin
                dm_we      = 1'b1;
                dm_waddr   = r_clr_addr;
                dm_wdata   = '0;
                rf_we      = (r_clr_addr < tce_pkg::MAW'(tce_pkg::REG_COUNT));
                rf_waddr   = r_clr_addr[tce_pkg::RIW-1:0];
                n_clr_addr = r_clr_addr + tce_pkg::MAW'(1);
                if (r_clr_addr == tce_pkg::MAW'(tce_pkg::MEM_WORDS - 1)) begin
                    n_state = tce_pkg::ST_READ;
                end
            end
            tce_pkg::ST_READ: begin
                if (i_iq_valid) begin
                    iq_pop  = 1'b1;
                    n_state = tce_pkg::ST_EXEC;
                end
            end
            tce_pkg::ST_EXEC: begin
                if (r_cur.iclass == tce_pkg::CL_LOAD && !exec_bad) begin
                    dm_re   = 1'b1;
                    n_state = tce_pkg::ST_LOAD;
                end else if (!rq_full) begin
                    rq_push      = 1'b1;
                    n_state      = tce_pkg::ST_READ;
                    push_res.bad = exec_bad;
                    unique case (r_cur.iclass)
                        tce_pkg::CL_ALU: begin
                            if (!exec_bad) begin
                                rf_we              = 1'b1;
                                rf_wdata           = alu_res;
                                push_res.reg_valid = 1'b1;
                                push_res.reg_index = r_cur.opd_c[tce_pkg::RIDX_OUT_W-1:0];
                                push_res.reg_value = alu_res;
                            end
                        end
                        tce_pkg::CL_CMP: begin
                            if (!exec_bad) begin
                                n_flag_eq = (val_a == val_b);
                                n_flag_gt = (val_a > val_b);
                                n_flag_lt = (val_a < val_b);
                            end
                        end
                        tce_pkg::CL_BRANCH: begin
                            if (taken && !exec_bad) begin
                                push_res.pc_valid = 1'b1;
                                push_res.pc_value = full_addr - tce_pkg::PC_OFFSET;
                            end
                        end
                        tce_pkg::CL_STORE: begin
                            dm_we = !exec_bad;
                        end
                        tce_pkg::CL_HALT: begin
                            push_res.halted = 1'b1;
                        end
                        default: begin
                            push_res.bad = exec_bad;
                        end
                    endcase
                end
            end
            tce_pkg::ST_LOAD: begin
                if (!rq_full) begin
                    rq_push            = 1'b1;
                    rf_we              = 1'b1;
                    rf_wdata           = dm_rdata;
                    push_res.reg_valid = 1'b1;
                    push_res.reg_index = r_cur.opd_c[tce_pkg::RIDX_OUT_W-1:0];
                    push_res.reg_value = dm_rdata;
                    n_state            = tce_pkg::ST_READ;
                end
            end
        endcase
    end

    // result queue pointers and count
    assign rq_pop = i_pop && (r_rq_count != '0);

    always_comb begin
        n_rq_wr    = r_rq_wr;
        n_rq_rd    = r_rq_rd;
        n_rq_count = r_rq_count;
        if (rq_push) begin
            n_rq_wr = (r_rq_wr == tce_pkg::RQ_PW'(tce_pkg::RQ_DEPTH - 1))
                      ? '0 : r_rq_wr + tce_pkg::RQ_PW'(1);
        end
        if (rq_pop) begin
            n_rq_rd = (r_rq_rd == tce_pkg::RQ_PW'(tce_pkg::RQ_DEPTH - 1))
                      ? '0 : r_rq_rd + tce_pkg::RQ_PW'(1);
        end
        if (rq_push && !rq_pop) begin
            n_rq_count = r_rq_count + tce_pkg::RQ_CW'(1);
        end else if (rq_pop && !rq_push) begin
            n_rq_count = r_rq_count - tce_pkg::RQ_CW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tce_pkg::ST_CLEAR;
            r_clr_addr <= '0;
            r_flag_eq  <= 1'b0;
            r_flag_gt  <= 1'b0;
            r_flag_lt  <= 1'b0;
            r_rq_wr    <= '0;
            r_rq_rd    <= '0;
            r_rq_count <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_flag_eq  <= n_flag_eq;
            r_flag_gt  <= n_flag_gt;
            r_flag_lt  <= n_flag_lt;
            r_rq_wr    <= n_rq_wr;
            r_rq_rd    <= n_rq_rd;
            r_rq_count <= n_rq_count;
        end
    end

    // payload: current instruction and result slots
    always_ff @(posedge i_clk) begin
        if (iq_pop) begin
            r_cur <= i_iq_item;
        end
        if (rq_push) begin
            r_rq[r_rq_wr] <= push_res;
        end
    end

    assign o_iq_pop   = iq_pop;
    assign o_clearing = (r_state == tce_pkg::ST_CLEAR);
    assign o_empty    = (r_rq_count == '0);
    assign o_result   = r_rq[r_rq_rd];

    // checks
    `TCE_ASSERT_IMP(a_push_in_exec, i_clk, i_rst_n, rq_push, (r_state == tce_pkg::ST_EXEC || r_state == tce_pkg::ST_LOAD))
    `TCE_ASSERT_IMP(a_store_only_write, i_clk, i_rst_n, (dm_we && r_state != tce_pkg::ST_CLEAR), (r_cur.iclass == tce_pkg::CL_STORE && !exec_bad))
    `TCE_ASSERT_NXT(a_load_to_wb, i_clk, i_rst_n, (r_state == tce_pkg::ST_EXEC && r_cur.iclass == tce_pkg::CL_LOAD && !exec_bad), (r_state == tce_pkg::ST_LOAD))
    `TCE_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, 1'b1, $onehot0({r_flag_eq, r_flag_gt, r_flag_lt}))
    `TCE_ASSERT_IMP(a_pc_alone, i_clk, i_rst_n, (rq_push && push_res.pc_valid), (!push_res.reg_valid && !push_res.bad))

endmodule

@@ hdl/toy_cpu_execute_stage.sv @@
// the back end pops each instruction from the queue in its read state, reading the register
// file, then executes it and pushes its result, a load passing a data memory read state first;
// it takes no new instruction until the last result is pushed into the result queue.
// a two-entry instruction queue and a two-entry result queue absorb stalls on either side.
// reset: synchronous active low; afterwards the data memory and register file are
// cleared over all MEM_WORDS (65536) addresses with full held high.
module toy_cpu_execute_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [tce_pkg::OP_W-1:0]       i_op,
    input  logic                           i_first_is_immediate,
    input  logic                           i_second_is_immediate,
    input  logic                           i_third_is_immediate,
    input  logic [tce_pkg::WORD_W-1:0]     i_first_operand,
    input  logic [tce_pkg::WORD_W-1:0]     i_second_operand,
    input  logic [tce_pkg::WORD_W-1:0]     i_third_operand,
    output logic                           empty,
    input  logic                           pop,
    output logic                           o_reg_write_valid,
    output logic [tce_pkg::RIDX_OUT_W-1:0] o_reg_write_index,
    output logic [tce_pkg::WORD_W-1:0]     o_reg_write_value,
    output logic                           o_pc_write_valid,
    output logic [tce_pkg::FULL_W-1:0]     o_pc_write_value,
    output logic                           o_halted,
    output logic                           o_bad_access
);

    tce_pkg::t_dec_item dec_item;
    tce_pkg::t_dec_item head_item;
    tce_pkg::t_result   result;
    logic               iq_full;
    logic               iq_valid;
    logic               iq_pop;
    logic               clearing;

    // decode
    tce_front u_front (
        .i_op                  (i_op),
        .i_first_is_immediate  (i_first_is_immediate),
        .i_second_is_immediate (i_second_is_immediate),
        .i_third_is_immediate  (i_third_is_immediate),
        .i_first_operand       (i_first_operand),
        .i_second_operand      (i_second_operand),
        .i_third_operand       (i_third_operand),
        .o_item                (dec_item)
    );

    // input transactions wait here until the back end takes them
    assign full = iq_full || clearing;

    tce_iq u_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_item  (dec_item),
        .o_full  (iq_full),
        .i_pop   (iq_pop),
        .o_valid (iq_valid),
        .o_item  (head_item)
    );

    // execute
    tce_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_iq_valid (iq_valid),
        .i_iq_item  (head_item),
        .o_iq_pop   (iq_pop),
        .o_clearing (clearing),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (result)
    );

    // result fields
    assign o_reg_write_valid = result.reg_valid;
    assign o_reg_write_index = result.reg_index;
    assign o_reg_write_value = result.reg_value;
    assign o_pc_write_valid  = result.pc_valid;
    assign o_pc_write_value  = result.pc_value;
    assign o_halted          = result.halted;
    assign o_bad_access      = result.bad;

endmodule

@@ tb/sv/toy_cpu_execute_stage_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the toy cpu execute stage
module toy_cpu_execute_stage_test;

    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned PAUSE_AT     = 500;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned END_SETTLE   = 10;
    // clearing pass after reset covers all 65536 data memory words with full high
    localparam int unsigned STALL_LIMIT  = 300000;

    // opcode with no defined meaning
    localparam logic [tce_pkg::OP_W-1:0] OP_UNUSED_TOP = 5'd31;

    // one decoded instruction as driven on the input ports
    typedef struct packed {
        logic [tce_pkg::OP_W-1:0]   op;
        logic                       imm1;
        logic                       imm2;
        logic                       imm3;
        logic [tce_pkg::WORD_W-1:0] a;
        logic [tce_pkg::WORD_W-1:0] b;
        logic [tce_pkg::WORD_W-1:0] c;
    } t_instr;

    // directed row: instruction and, where typed, its known outcome
    typedef struct packed {
        t_instr           ins;
        bit               typed;
        tce_pkg::t_result res;
    } t_row;

    localparam tce_pkg::t_result NO_EFFECT = '0;
    localparam tce_pkg::t_result BAD_ONLY  = '{1'b0, 4'd0, 16'h0, 1'b0, 32'h0, 1'b0, 1'b1};

    localparam t_row DIRECTED_ROWS [0:26] = '{
        '{'{tce_pkg::OP_NONE, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, NO_EFFECT},
        '{'{tce_pkg::OP_MOVE, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'd15}, 1'b1,
          '{1'b1, 4'd15, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0}},
        // move never reads its second operand
        '{'{tce_pkg::OP_MOVE, 1'b1, 1'b0, 1'b0, 16'h0001, 16'hFFFF, 16'd1}, 1'b1,
          '{1'b1, 4'd1, 16'h0001, 1'b0, 32'h0, 1'b0, 1'b0}},
        '{'{tce_pkg::OP_ADD, 1'b0, 1'b0, 1'b0, 16'd15, 16'd1, 16'd2}, 1'b1,
          '{1'b1, 4'd2, 16'h0000, 1'b0, 32'h0, 1'b0, 1'b0}},
        '{'{tce_pkg::OP_SUB, 1'b0, 1'b1, 1'b0, 16'd2, 16'h0001, 16'd3}, 1'b0, NO_EFFECT},
        '{'{tce_pkg::OP_AND, 1'b0, 1'b1, 1'b0, 16'd15, 16'h00FF, 16'd4}, 1'b0, NO_EFFECT},
        '{'{tce_pkg::OP_OR, 1'b1, 1'b1, 1'b0, 16'hA5A5, 16'h5A5A, 16'd5}, 1'b0, NO_EFFECT},
        // not never reads its second operand
        '{'{tce_pkg::OP_NOT, 1'b1, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 16'd6}, 1'b1,
          '{1'b1, 4'd6, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0}},
        '{'{tce_pkg::OP_NAND, 1'b0, 1'b0, 1'b0, 16'd15, 16'd15, 16'd7}, 1'b0, NO_EFFECT},
        '{'{tce_pkg::OP_NOR, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'd8}, 1'b0, NO_EFFECT},
        '{'{tce_pkg::OP_XOR, 1'b0, 1'b1, 1'b0, 16'd1, 16'hFFFF, 16'd9}, 1'b0, NO_EFFECT},
        // bad source register index
        '{'{tce_pkg::OP_ADD, 1'b0, 1'b1, 1'b0, 16'd16, 16'h0001, 16'd0}, 1'b1, BAD_ONLY},
        // bad destination register index
        '{'{tce_pkg::OP_MOVE, 1'b1, 1'b1, 1'b0, 16'h1234, 16'h0000, 16'hFFFF}, 1'b1, BAD_ONLY},
        '{'{tce_pkg::OP_CMP, 1'b1, 1'b1, 1'b0, 16'd5, 16'd5, 16'd0}, 1'b1, NO_EFFECT},
        '{'{tce_pkg::OP_BEQ, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'd0}, 1'b1,
          '{1'b0, 4'd0, 16'h0, 1'b1, 32'hFFFF_FFFC, 1'b0, 1'b0}},
        // untaken branch does not read its bad indexes
        '{'{tce_pkg::OP_BNE, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1, NO_EFFECT},
        '{'{tce_pkg::OP_CMP, 1'b0, 1'b1, 1'b0, 16'd15, 16'h0000, 16'd0}, 1'b1, NO_EFFECT},
        '{'{tce_pkg::OP_BGT, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0}, 1'b1,
          '{1'b0, 4'd0, 16'h0, 1'b1, 32'hFFFF_FFFB, 1'b0, 1'b0}},
        '{'{tce_pkg::OP_BLT, 1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'd0}, 1'b0, NO_EFFECT},
        '{'{tce_pkg::OP_JMP, 1'b1, 1'b1, 1'b0, 16'h0004, 16'h0000, 16'd0}, 1'b1,
          '{1'b0, 4'd0, 16'h0, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{'{tce_pkg::OP_JMP, 1'b0, 1'b1, 1'b0, 16'd20, 16'h0000, 16'd0}, 1'b1, BAD_ONLY},
        '{'{tce_pkg::OP_STORE, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'hBEEF}, 1'b1, NO_EFFECT},
        '{'{tce_pkg::OP_LOAD, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'd10}, 1'b1,
          '{1'b1, 4'd10, 16'hBEEF, 1'b0, 32'h0, 1'b0, 1'b0}},
        // address just past the end of memory
        '{'{tce_pkg::OP_STORE, 1'b1, 1'b1, 1'b1, 16'h0000, 16'h0001, 16'hBEEF}, 1'b1, BAD_ONLY},
        '{'{tce_pkg::OP_LOAD, 1'b1, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'd11}, 1'b1, BAD_ONLY},
        '{'{tce_pkg::OP_HALT, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1,
          '{1'b0, 4'd0, 16'h0, 1'b0, 32'h0, 1'b1, 1'b0}},
        '{'{OP_UNUSED_TOP, 1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, NO_EFFECT}
    };

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic [tce_pkg::OP_W-1:0]       i_op = '0;
    logic                           i_first_is_immediate = 1'b0;
    logic                           i_second_is_immediate = 1'b0;
    logic                           i_third_is_immediate = 1'b0;
    logic [tce_pkg::WORD_W-1:0]     i_first_operand = '0;
    logic [tce_pkg::WORD_W-1:0]     i_second_operand = '0;
    logic [tce_pkg::WORD_W-1:0]     i_third_operand = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           o_reg_write_valid;
    logic [tce_pkg::RIDX_OUT_W-1:0] o_reg_write_index;
    logic [tce_pkg::WORD_W-1:0]     o_reg_write_value;
    logic                           o_pc_write_valid;
    logic [tce_pkg::FULL_W-1:0]     o_pc_write_value;
    logic                           o_halted;
    logic                           o_bad_access;

    // architectural state mirrored by the testbench
    bit [tce_pkg::WORD_W-1:0] arch_regs [tce_pkg::REG_COUNT];
    bit [tce_pkg::WORD_W-1:0] arch_mem [tce_pkg::MEM_WORDS];
    bit                       flag_eq;
    bit                       flag_gt;
    bit                       flag_lt;

    tce_pkg::t_result pending_results [$];
    int unsigned      n_accepted = 0;
    int unsigned      n_errors = 0;
    int unsigned      quiet_cycles = 0;

    toy_cpu_execute_stage u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .push                  (push),
        .full                  (full),
        .i_op                  (i_op),
        .i_first_is_immediate  (i_first_is_immediate),
        .i_second_is_immediate (i_second_is_immediate),
        .i_third_is_immediate  (i_third_is_immediate),
        .i_first_operand       (i_first_operand),
        .i_second_operand      (i_second_operand),
        .i_third_operand       (i_third_operand),
        .empty                 (empty),
        .pop                   (pop),
        .o_reg_write_valid     (o_reg_write_valid),
        .o_reg_write_index     (o_reg_write_index),
        .o_reg_write_value     (o_reg_write_value),
        .o_pc_write_valid      (o_pc_write_valid),
        .o_pc_write_value      (o_pc_write_value),
        .o_halted              (o_halted),
        .o_bad_access          (o_bad_access)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit bad_index(input logic [tce_pkg::WORD_W-1:0] raw,
                                     input logic literal);
        return !literal && raw >= tce_pkg::REG_COUNT;
    endfunction

    function automatic logic [tce_pkg::WORD_W-1:0] operand_value(
        input logic [tce_pkg::WORD_W-1:0] raw, input logic literal);
        if (literal)
            return raw;
        if (raw >= tce_pkg::REG_COUNT)
            return '0;
        return arch_regs[raw[tce_pkg::RIW-1:0]];
    endfunction

    // executes one instruction on the mirrored state and returns its outcome
    function automatic tce_pkg::t_result execute_instr(input t_instr ins);
        tce_pkg::t_result           r;
        logic [tce_pkg::WORD_W-1:0] a;
        logic [tce_pkg::WORD_W-1:0] b;
        logic [tce_pkg::WORD_W-1:0] val;
        logic [tce_pkg::FULL_W-1:0] addr;
        bit                         bad;
        bit                         taken;
        r     = '0;
        a     = operand_value(ins.a, ins.imm1);
        b     = operand_value(ins.b, ins.imm2);
        addr  = {b, a};
        val   = '0;
        bad   = 1'b0;
        taken = 1'b0;
        case (ins.op)
            tce_pkg::OP_MOVE, tce_pkg::OP_ADD, tce_pkg::OP_SUB, tce_pkg::OP_AND,
            tce_pkg::OP_OR, tce_pkg::OP_NOT, tce_pkg::OP_NAND, tce_pkg::OP_NOR,
            tce_pkg::OP_XOR: begin
                bad = bad_index(ins.a, ins.imm1) || ins.c >= tce_pkg::REG_COUNT
                    || (ins.op != tce_pkg::OP_MOVE && ins.op != tce_pkg::OP_NOT
                        && bad_index(ins.b, ins.imm2));
                case (ins.op)
                    tce_pkg::OP_MOVE: val = a;
                    tce_pkg::OP_ADD:  val = a + b;
                    tce_pkg::OP_SUB:  val = a - b;
                    tce_pkg::OP_AND:  val = a & b;
                    tce_pkg::OP_OR:   val = a | b;
                    tce_pkg::OP_NOT:  val = ~a;
                    tce_pkg::OP_NAND: val = ~(a & b);
                    tce_pkg::OP_NOR:  val = ~(a | b);
                    default:          val = a ^ b;
                endcase
                if (!bad) begin
                    arch_regs[ins.c[tce_pkg::RIW-1:0]] = val;
                    r.reg_valid = 1'b1;
                    r.reg_index = ins.c[tce_pkg::RIDX_OUT_W-1:0];
                    r.reg_value = val;
                end
            end
            tce_pkg::OP_CMP: begin
                bad = bad_index(ins.a, ins.imm1) || bad_index(ins.b, ins.imm2);
                if (!bad) begin
                    flag_eq = (a == b);
                    flag_gt = (a > b);
                    flag_lt = (a < b);
                end
            end
            tce_pkg::OP_JMP, tce_pkg::OP_BEQ, tce_pkg::OP_BNE, tce_pkg::OP_BGT,
            tce_pkg::OP_BLT: begin
                case (ins.op)
                    tce_pkg::OP_JMP: taken = 1'b1;
                    tce_pkg::OP_BEQ: taken = flag_eq;
                    tce_pkg::OP_BNE: taken = !flag_eq;
                    tce_pkg::OP_BGT: taken = flag_gt;
                    default:         taken = flag_lt;
                endcase
                // operands of an untaken branch are not read
                if (taken) begin
                    bad = bad_index(ins.a, ins.imm1) || bad_index(ins.b, ins.imm2);
                    if (!bad) begin
                        r.pc_valid = 1'b1;
                        r.pc_value = addr - tce_pkg::PC_OFFSET;
                    end
                end
            end
            tce_pkg::OP_LOAD: begin
                bad = bad_index(ins.a, ins.imm1) || bad_index(ins.b, ins.imm2)
                    || ins.c >= tce_pkg::REG_COUNT || addr >= tce_pkg::MEM_WORDS;
                if (!bad) begin
                    val = arch_mem[addr[tce_pkg::MAW-1:0]];
                    arch_regs[ins.c[tce_pkg::RIW-1:0]] = val;
                    r.reg_valid = 1'b1;
                    r.reg_index = ins.c[tce_pkg::RIDX_OUT_W-1:0];
                    r.reg_value = val;
                end
            end
            tce_pkg::OP_STORE: begin
                bad = bad_index(ins.a, ins.imm1) || bad_index(ins.b, ins.imm2)
                    || bad_index(ins.c, ins.imm3) || addr >= tce_pkg::MEM_WORDS;
                if (!bad)
                    arch_mem[addr[tce_pkg::MAW-1:0]] = operand_value(ins.c, ins.imm3);
            end
            tce_pkg::OP_HALT: r.halted = 1'b1;
            default: ;
        endcase
        r.bad = bad;
        return r;
    endfunction

    function automatic logic [tce_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 4))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return tce_pkg::WORD_W'($urandom_range(0, 15));
            default: return tce_pkg::WORD_W'($urandom());
        endcase
    endfunction

    // mostly valid register indexes, now and then an out-of-range one
    function automatic logic [tce_pkg::WORD_W-1:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return tce_pkg::WORD_W'($urandom_range(tce_pkg::REG_COUNT, 16'hFFFF));
        return tce_pkg::WORD_W'($urandom_range(0, tce_pkg::REG_COUNT - 1));
    endfunction

    // a few addresses at both ends so loads find earlier stores
    function automatic logic [tce_pkg::WORD_W-1:0] pick_address();
        case ($urandom_range(0, 3))
            0:       return pick_word();
            1:       return 16'hFFFF - tce_pkg::WORD_W'($urandom_range(0, 7));
            default: return tce_pkg::WORD_W'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic t_instr random_instr();
        t_instr      ins;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            ins.op = tce_pkg::OP_W'($urandom_range(0, 31));
        else if (pick < 32)
            ins.op = tce_pkg::OP_W'($urandom_range(tce_pkg::OP_MOVE, tce_pkg::OP_XOR));
        else if (pick < 42)
            ins.op = tce_pkg::OP_CMP;
        else if (pick < 58)
            ins.op = tce_pkg::OP_W'($urandom_range(tce_pkg::OP_JMP, tce_pkg::OP_BLT));
        else if (pick < 77)
            ins.op = tce_pkg::OP_LOAD;
        else if (pick < 96)
            ins.op = tce_pkg::OP_STORE;
        else
            ins.op = tce_pkg::OP_HALT;
        ins.imm1 = 1'($urandom_range(0, 1));
        ins.imm2 = 1'($urandom_range(0, 1));
        ins.imm3 = 1'($urandom_range(0, 1));
        if (ins.op == tce_pkg::OP_LOAD || ins.op == tce_pkg::OP_STORE) begin
            ins.a = ins.imm1 ? pick_address() : pick_index();
            if (ins.imm2)
                ins.b = ($urandom_range(0, 7) == 0) ? pick_word() : 16'h0000;
            else
                ins.b = pick_index();
        end else begin
            ins.a = ins.imm1 ? pick_word() : pick_index();
            ins.b = ins.imm2 ? pick_word() : pick_index();
        end
        ins.c = (ins.op == tce_pkg::OP_STORE && ins.imm3) ? pick_word() : pick_index();
        return ins;
    endfunction

    // offer one instruction until accepted, then record its outcome
    task automatic issue(input t_instr ins, input bit typed,
                         input tce_pkg::t_result typed_res);
        tce_pkg::t_result r;
        push                  <= 1'b1;
        i_op                  <= ins.op;
        i_first_is_immediate  <= ins.imm1;
        i_second_is_immediate <= ins.imm2;
        i_third_is_immediate  <= ins.imm3;
        i_first_operand       <= ins.a;
        i_second_operand      <= ins.b;
        i_third_operand       <= ins.c;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        r = execute_instr(ins);
        pending_results.push_back(typed ? typed_res : r);
        n_accepted++;
    endtask

    task automatic idle_sender(input int unsigned cycles);
        push <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        idle_sender(1);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    function void check_field(input string name, input logic [tce_pkg::FULL_W-1:0] want,
                              input logic [tce_pkg::FULL_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        tce_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: result transaction with nothing outstanding", $time);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("reg_write_valid", want.reg_valid, o_reg_write_valid);
                check_field("reg_write_index", want.reg_index, o_reg_write_index);
                check_field("reg_write_value", want.reg_value, o_reg_write_value);
                check_field("pc_write_valid", want.pc_valid, o_pc_write_valid);
                check_field("pc_write_value", want.pc_value, o_pc_write_value);
                check_field("halted", want.halted, o_halted);
                check_field("bad_access", want.bad, o_bad_access);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: randomly chosen stall patterns, one long hold-off
    initial begin : receiver
        int unsigned cyc;
        int unsigned mode;
        bit          hold_done;
        cyc       = 0;
        mode      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 128 == 0)
                mode = $urandom_range(0, 3);
            if (!hold_done && n_accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= (cyc % 4 == 0);
                    default: pop <= ((cyc / 8) % 2 == 0);
                endcase
            end
        end
    end

    // sender and end of run
    initial begin : sender
        int unsigned n_random;
        int unsigned burst;
        int unsigned gap_sel;
        bit          paused;
        n_random = 0;
        paused   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (DIRECTED_ROWS[k]) begin
            issue(DIRECTED_ROWS[k].ins, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].res);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 3));
        end
        wait_all_results();

        // random bursts with random gaps
        while (n_random < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                issue(random_instr(), 1'b0, NO_EFFECT);
                n_random++;
            end
            gap_sel = $urandom_range(0, 9);
            if (!paused && n_random >= PAUSE_AT) begin
                paused = 1'b1;
                wait_all_results();
            end else if (gap_sel >= 8)
                idle_sender($urandom_range(5, 20));
            else if (gap_sel >= 4)
                idle_sender($urandom_range(1, 4));
        end

        wait_all_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
